@@ rtl/sorted_insert_priority_queue_macros.svh @@
// ----------------------------------------------------------------------------
// sorted insert priority queue assertion macros
// shared concurrent assertion forms, clocked on clk_i and masked by rst_ni
// ----------------------------------------------------------------------------
`ifndef SORTED_INSERT_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_MACROS_SVH

// property must hold at every edge out of reset
`define SIQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("siq: property violated");

// condition must never be true out of reset
`define SIQ_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("siq: forbidden condition seen");

`endif

@@ rtl/siq_pkg.sv @@
// ----------------------------------------------------------------------------
// siq_pkg
// shared types and constants of the sorted insert priority queue
// ----------------------------------------------------------------------------
package siq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned PRIO_W    = 8;
  localparam int unsigned ENTRY_W   = ID_W + PRIO_W;
  localparam int unsigned STATUS_W  = 2;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // one result as handed from the sequencer to the output stage
  typedef struct packed {
    status_e             status;
    logic [ID_W-1:0]     proc_id;
    logic [PRIO_W-1:0]   prio;
  } res_t;

endpackage

@@ rtl/siq_ram.sv @@
// ----------------------------------------------------------------------------
// siq_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module siq_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/siq_ctrl.sv @@
// ----------------------------------------------------------------------------
// siq_ctrl
// request sequencer: ring pointers, insertion walk and dequeue over the ram
// ----------------------------------------------------------------------------
`include "sorted_insert_priority_queue_macros.svh"

module siq_ctrl #(
  parameter int unsigned DEPTH = siq_pkg::DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request side
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [siq_pkg::ID_W-1:0]      proc_id_i,
  input  logic [siq_pkg::PRIO_W-1:0]    prio_in_i,
  // result side
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output siq_pkg::res_t                 res_o,
  // ram port
  output logic                          we_o,
  output logic [$clog2(DEPTH)-1:0]      waddr_o,
  output logic [siq_pkg::ENTRY_W-1:0]   wdata_o,
  output logic [$clog2(DEPTH)-1:0]      raddr_o,
  input  logic [siq_pkg::ENTRY_W-1:0]   rdata_i
);

  import siq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUT,
    ST_DEQ,
    ST_DONE
  } state_e;

  state_e             state_q;
  logic [AW-1:0]      head_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      k_q;
  logic [AW-1:0]      cur_q;
  logic [ID_W-1:0]    id_q;
  logic [PRIO_W-1:0]  prio_q;
  res_t               res_q;

  logic               accept;
  logic               shift_back;
  logic [AW-1:0]      tail_slot;
  logic [PRIO_W-1:0]  rd_prio;

  // (base + off) mod DEPTH, with base and off both below DEPTH
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [AW:0] sum;
    sum = (AW+1)'(base) + (AW+1)'(off);
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] i);
    return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
  endfunction

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;
  assign rd_prio     = rdata_i[PRIO_W-1:0];
  assign shift_back  = (rd_prio > prio_q);
  assign tail_slot   = wrap_add(head_q, count_q - 1'b1);

  // ram port; the walk writes two slots above the one it reads next, so the
  // two never meet while live data is involved
  always_comb begin
    we_o    = 1'b0;
    waddr_o = cur_q;
    wdata_o = {id_q, prio_q};
    raddr_o = head_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && opcode_i == OP_ENQ) begin
          if (count_q == '0) begin
            we_o    = 1'b1;
            waddr_o = '0;
            wdata_o = {proc_id_i, prio_in_i};
          end else begin
            raddr_o = tail_slot;
          end
        end
      end
      ST_SCAN: begin
        we_o    = 1'b1;
        waddr_o = next_slot(cur_q);
        if (shift_back) begin
          wdata_o = rdata_i;
          raddr_o = prev_slot(cur_q);
        end
      end
      ST_PUT: begin
        we_o    = 1'b1;
        waddr_o = head_q;
      end
      ST_DEQ, ST_DONE: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
      k_q     <= '0;
      cur_q   <= '0;
      id_q    <= '0;
      prio_q  <= '0;
      res_q   <= '{status: STATUS_OK, proc_id: '0, prio: '0};
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            id_q   <= proc_id_i;
            prio_q <= prio_in_i;
            if (opcode_i == OP_ENQ) begin
              if (count_q == CW'(DEPTH)) begin
                res_q   <= '{status: STATUS_FULL, proc_id: '0, prio: '0};
                state_q <= ST_DONE;
              end else begin
                res_q <= '{status: STATUS_OK, proc_id: '0, prio: '0};
                if (count_q == '0) begin
                  head_q  <= '0;
                  count_q <= CW'(1);
                  state_q <= ST_DONE;
                end else begin
                  k_q     <= count_q;
                  cur_q   <= tail_slot;
                  state_q <= ST_SCAN;
                end
              end
            end else begin
              if (count_q == '0) begin
                res_q   <= '{status: STATUS_EMPTY, proc_id: '0, prio: '0};
                state_q <= ST_DONE;
              end else begin
                state_q <= ST_DEQ;
              end
            end
          end
        end
        ST_SCAN: begin
          if (shift_back) begin
            if (k_q == CW'(1)) begin
              state_q <= ST_PUT;
            end else begin
              k_q   <= k_q - 1'b1;
              cur_q <= prev_slot(cur_q);
            end
          end else begin
            count_q <= count_q + 1'b1;
            state_q <= ST_DONE;
          end
        end
        ST_PUT: begin
          count_q <= count_q + 1'b1;
          state_q <= ST_DONE;
        end
        ST_DEQ: begin
          res_q   <= '{status: STATUS_OK, proc_id: rdata_i[ENTRY_W-1:PRIO_W],
                       prio: rd_prio};
          count_q <= count_q - 1'b1;
          head_q  <= (count_q == CW'(1)) ? '0 : next_slot(head_q);
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
      endcase
    end
  end

  `SIQ_ASSERT_NEVER(a_count_bound, count_q > CW'(DEPTH))
  `SIQ_ASSERT(a_empty_head_zero, (count_q == '0) |-> (head_q == '0))
  `SIQ_ASSERT(a_walk_in_range, (state_q == ST_SCAN) |-> (k_q != '0 && k_q < CW'(DEPTH)))
  `SIQ_ASSERT(a_no_write_when_done, (state_q == ST_DONE || state_q == ST_DEQ) |-> !we_o)
  `SIQ_ASSERT(a_deq_needs_entry, (state_q == ST_DEQ) |-> (count_q != '0))

endmodule

@@ rtl/sorted_insert_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue
// bounded priority queue kept sorted in one ram ring, smallest value first
// ----------------------------------------------------------------------------
// sequencing: a full or empty reject and an enqueue into an empty queue go
//   from IDLE straight to DONE, a dequeue passes through DEQ, and an enqueue
//   stays in SCAN for each entry it moves back and ends in PUT or DONE
// requests: taken one at a time, only in IDLE; the single ram read port
//   walks one entry per cycle from the tail toward the head on insertion
// reset: control cleared, queue empty with head at slot zero; ram not cleared
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue #(
  parameter int unsigned DEPTH = siq_pkg::DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [siq_pkg::ID_W-1:0]      proc_id_i,
  input  logic [siq_pkg::PRIO_W-1:0]    prio_in_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [siq_pkg::STATUS_W-1:0]  status_o,
  output logic [siq_pkg::ID_W-1:0]      proc_out_o,
  output logic [siq_pkg::PRIO_W-1:0]    prio_out_o
);

  import siq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  // sequencer to output stage
  logic                 res_valid;
  logic                 res_ready;
  res_t                 res;

  // ram port
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;

  // output register
  logic                 out_valid_q;
  res_t                 out_res_q;
  logic                 out_load;

  // entries {id, prio}, ring ordered by ascending priority from head
  siq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // pointer bookkeeping and the insertion walk
  siq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .proc_id_i   (proc_id_i),
    .prio_in_i   (prio_in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .we_o        (ram_we),
    .waddr_o     (ram_waddr),
    .wdata_o     (ram_wdata),
    .raddr_o     (ram_raddr),
    .rdata_i     (ram_rdata)
  );

  // output register frees the sequencer while a result waits downstream
  assign res_ready = !out_valid_q || out_ready_i;
  assign out_load  = res_valid && res_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_res_q.status;
  assign proc_out_o  = out_res_q.proc_id;
  assign prio_out_o  = out_res_q.prio;

endmodule
